>>> rtl/pam_pkg.sv
// Shared constants for the pyramidal attention mask block.
`timescale 1ns / 1ps

package pam_pkg;

	// Default sizing
	localparam int MAX_LEVELS_DEF = 4;
	localparam int MAX_INPUT_DEF  = 512;

	// Port widths fixed by the register map and the index fields
	localparam int IDX_W  = 10;
	localparam int DATA_W = 10;
	localparam int REG_W  = 3;
	localparam int LEN_W  = 10;
	localparam int LVL_W  = 3;
	localparam int WIN_W  = 5;
	localparam int WINS   = 4;

	// Register indexes
	localparam logic [REG_W-1:0] REG_INPUT_LENGTH = 3'd0;
	localparam logic [REG_W-1:0] REG_LEVEL_COUNT  = 3'd1;
	localparam logic [REG_W-1:0] REG_WINDOW_ONE   = 3'd2;
	localparam logic [REG_W-1:0] REG_WINDOW_TWO   = 3'd3;
	localparam logic [REG_W-1:0] REG_WINDOW_THREE = 3'd4;
	localparam logic [REG_W-1:0] REG_WINDOW_FOUR  = 3'd5;
	localparam logic [REG_W-1:0] REG_INNER_WIDTH  = 3'd6;

	// Register reset values
	localparam logic [LEN_W-1:0] RST_INPUT_LENGTH = 10'd512;
	localparam logic [LVL_W-1:0] RST_LEVEL_COUNT  = 3'd3;
	localparam logic [WIN_W-1:0] RST_WINDOW       = 5'd4;
	localparam logic [WIN_W-1:0] RST_INNER_WIDTH  = 5'd3;

	// Smallest legal window
	localparam logic [WIN_W-1:0] MIN_WINDOW = 5'd2;

endpackage

>>> rtl/pyramidal_attention_mask.sv
// Pyramidal attention mask: scale table builder and four-stage mask pipeline.
`timescale 1ns / 1ps

// Takes one (row_index, column_index) request per cycle while busy is low and returns
// blocked and out_of_range from the last mask pipeline stage with done high for one
// cycle; results cannot be held off. Scale sizes are built by a shared restoring
// divider, one quotient bit per cycle, each quotient $clog2(MAX_INPUT + 1) bits wide:
// after reset and after every register write busy stays high while the builder runs
// INIT and then DIV and STORE once for each effective level.
module pyramidal_attention_mask #(
	parameter int MAX_LEVELS = pam_pkg::MAX_LEVELS_DEF,
	parameter int MAX_INPUT  = pam_pkg::MAX_INPUT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [pam_pkg::IDX_W-1:0]   row_index,
	input  logic [pam_pkg::IDX_W-1:0]   column_index,
	output logic                        done,
	output logic                        blocked,
	output logic                        out_of_range,
	input  logic                        wr_en,
	input  logic [pam_pkg::REG_W-1:0]   wr_index,
	input  logic [pam_pkg::DATA_W-1:0]  wr_data
);

	localparam int NS    = MAX_LEVELS + 1;
	localparam int MAXLV = (MAX_LEVELS < 4) ? MAX_LEVELS : 4;
	localparam int SW    = $clog2(MAX_INPUT + 1);
	localparam int PW    = SW + 1;
	localparam int LW    = (SW > pam_pkg::LEN_W) ? SW : pam_pkg::LEN_W;
	localparam int XW    = (PW > pam_pkg::IDX_W) ? PW : pam_pkg::IDX_W;
	localparam int LVW   = $clog2(NS);
	localparam int CW    = $clog2(SW);
	localparam int WW    = pam_pkg::WIN_W;
	localparam int MW    = SW + WW;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_INIT  = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;
	localparam logic [1:0] ST_STORE = 2'd3;

	// Configuration registers
	logic [pam_pkg::LEN_W-1:0] input_length_q;
	logic [pam_pkg::LVL_W-1:0] level_count_q;
	logic [WW-1:0]             window_q [pam_pkg::WINS];
	logic [WW-1:0]             inner_width_q;

	// Scale table
	logic [SW-1:0] scale_size_q  [NS];
	logic [PW-1:0] scale_start_q [NS];
	logic [PW-1:0] scale_end_q   [NS];
	logic [WW-1:0] scale_win_q   [NS];
	logic [PW-1:0] total_q;

	// Builder
	logic [1:0]     state_q;
	logic [LVW-1:0] lvl_q;
	logic [PW-1:0]  pos_q;
	logic [SW-1:0]  div_q;
	logic [WW-1:0]  rem_q;
	logic [CW-1:0]  cnt_q;

	logic [LW-1:0]  len_ext;
	logic [SW-1:0]  n_eff;
	logic [LVW-1:0] lv_eff;
	logic [1:0]     wsel;
	logic [WW-1:0]  w_cur;
	logic [WW:0]    trial;
	logic           take;
	logic           accept;

	always_comb begin
		len_ext = LW'(input_length_q);
		if (len_ext == '0) begin
			n_eff = SW'(1);
		end else if (len_ext > LW'(MAX_INPUT)) begin
			n_eff = SW'(MAX_INPUT);
		end else begin
			n_eff = SW'(len_ext);
		end
		if (int'(level_count_q) > MAXLV) begin
			lv_eff = LVW'(MAXLV);
		end else begin
			lv_eff = LVW'(level_count_q);
		end
		wsel  = 2'(lvl_q - LVW'(1));
		w_cur = (window_q[wsel] < pam_pkg::MIN_WINDOW) ? pam_pkg::MIN_WINDOW : window_q[wsel];
		trial = {rem_q, div_q[SW-1]};
		take  = trial >= {1'b0, w_cur};
	end

	assign busy   = state_q != ST_IDLE;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_length_q <= pam_pkg::RST_INPUT_LENGTH;
			level_count_q  <= pam_pkg::RST_LEVEL_COUNT;
			for (int i = 0; i < pam_pkg::WINS; i++) begin
				window_q[i] <= pam_pkg::RST_WINDOW;
			end
			inner_width_q  <= pam_pkg::RST_INNER_WIDTH;
		end else if (wr_en) begin
			unique case (wr_index)
				pam_pkg::REG_INPUT_LENGTH: input_length_q <= wr_data[pam_pkg::LEN_W-1:0];
				pam_pkg::REG_LEVEL_COUNT:  level_count_q  <= wr_data[pam_pkg::LVL_W-1:0];
				pam_pkg::REG_WINDOW_ONE:   window_q[0]    <= wr_data[WW-1:0];
				pam_pkg::REG_WINDOW_TWO:   window_q[1]    <= wr_data[WW-1:0];
				pam_pkg::REG_WINDOW_THREE: window_q[2]    <= wr_data[WW-1:0];
				pam_pkg::REG_WINDOW_FOUR:  window_q[3]    <= wr_data[WW-1:0];
				pam_pkg::REG_INNER_WIDTH:  inner_width_q  <= wr_data[WW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Scale table builder: one divide per coarser level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			lvl_q   <= '0;
			cnt_q   <= '0;
		end else if (wr_en && (wr_index <= pam_pkg::REG_INNER_WIDTH)) begin
			state_q <= ST_INIT;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					lvl_q <= LVW'(1);
					cnt_q <= '0;
					state_q <= (lv_eff == '0) ? ST_IDLE : ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(SW - 1)) begin
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					cnt_q <= '0;
					if (lvl_q == lv_eff) begin
						state_q <= ST_IDLE;
					end else begin
						lvl_q   <= lvl_q + LVW'(1);
						state_q <= ST_DIV;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_INIT: begin
				for (int s = 0; s < NS; s++) begin
					scale_size_q[s]  <= '0;
					scale_start_q[s] <= '0;
					scale_end_q[s]   <= '0;
					scale_win_q[s]   <= pam_pkg::MIN_WINDOW;
				end
				scale_size_q[0] <= n_eff;
				scale_end_q[0]  <= PW'(n_eff);
				pos_q   <= PW'(n_eff);
				total_q <= PW'(n_eff);
				div_q   <= n_eff;
				rem_q   <= '0;
			end
			ST_DIV: begin
				rem_q <= take ? WW'(trial - {1'b0, w_cur}) : WW'(trial);
				div_q <= {div_q[SW-2:0], take};
			end
			ST_STORE: begin
				scale_size_q[lvl_q]  <= div_q;
				scale_start_q[lvl_q] <= pos_q;
				scale_end_q[lvl_q]   <= pos_q + PW'(div_q);
				scale_win_q[lvl_q]   <= w_cur;
				pos_q   <= pos_q + PW'(div_q);
				total_q <= pos_q + PW'(div_q);
				rem_q   <= '0;
			end
			default: begin
			end
		endcase
	end

	// Stage 1: scale membership, offsets, range and neighborhood checks
	logic                          v_s1;
	logic [NS-1:0]                 mr_s1, mc_s1;
	logic [SW-1:0]                 offr_s1 [NS];
	logic [SW-1:0]                 offc_s1 [NS];
	logic                          oor_s1, near_s1;
	logic [XW-1:0]                 r_x, c_x;
	logic [pam_pkg::IDX_W-1:0]     gap;

	always_comb begin
		r_x = XW'(row_index);
		c_x = XW'(column_index);
		gap = (row_index > column_index) ? row_index - column_index
		                                 : column_index - row_index;
	end

	always_ff @(posedge clk) begin
		for (int s = 0; s < NS; s++) begin
			mr_s1[s]   <= (r_x >= XW'(scale_start_q[s])) && (r_x < XW'(scale_end_q[s]));
			mc_s1[s]   <= (c_x >= XW'(scale_start_q[s])) && (c_x < XW'(scale_end_q[s]));
			offr_s1[s] <= SW'(r_x - XW'(scale_start_q[s]));
			offc_s1[s] <= SW'(c_x - XW'(scale_start_q[s]));
		end
		oor_s1  <= (r_x >= XW'(total_q)) || (c_x >= XW'(total_q));
		near_s1 <= gap <= pam_pkg::IDX_W'(inner_width_q >> 1);
	end

	// Stage 2: relation between the two scales and parent / child offsets
	logic          v_s2;
	logic          same_s2, link_s2, near_s2, oor_s2;
	logic [SW-1:0] p_s2, q_s2, psize_s2;
	logic [WW-1:0] w_s2;

	logic          up, down;
	logic [NS-1:0] par;
	logic [SW-1:0] p_sel, q_sel, size_sel, or_sel, oc_sel;
	logic [WW-1:0] w_sel;

	always_comb begin
		up    = |(mr_s1 & (mc_s1 << 1));
		down  = |(mc_s1 & (mr_s1 << 1));
		par   = up ? mr_s1 : mc_s1;
		or_sel   = '0;
		oc_sel   = '0;
		size_sel = '0;
		w_sel    = '0;
		for (int s = 0; s < NS; s++) begin
			or_sel   = or_sel   | (offr_s1[s] & {SW{mr_s1[s]}});
			oc_sel   = oc_sel   | (offc_s1[s] & {SW{mc_s1[s]}});
			size_sel = size_sel | (scale_size_q[s] & {SW{par[s]}});
			w_sel    = w_sel    | (scale_win_q[s] & {WW{par[s]}});
		end
		p_sel = up ? or_sel : oc_sel;
		q_sel = up ? oc_sel : or_sel;
	end

	always_ff @(posedge clk) begin
		same_s2  <= |(mr_s1 & mc_s1);
		link_s2  <= up || down;
		near_s2  <= near_s1;
		oor_s2   <= oor_s1;
		p_s2     <= p_sel;
		q_s2     <= q_sel;
		psize_s2 <= size_sel;
		w_s2     <= w_sel;
	end

	// Stage 3: bounds of the parent's child window
	logic          v_s3;
	logic          same_s3, link_s3, near_s3, oor_s3, last_s3;
	logic [MW-1:0] lo_s3, hi_s3;
	logic [SW-1:0] q_s3;
	logic [MW-1:0] prod;

	assign prod = MW'(p_s2) * MW'(w_s2);

	always_ff @(posedge clk) begin
		same_s3 <= same_s2;
		link_s3 <= link_s2;
		near_s3 <= near_s2;
		oor_s3  <= oor_s2;
		last_s3 <= (p_s2 + SW'(1)) == psize_s2;
		lo_s3   <= prod;
		hi_s3   <= prod + MW'(w_s2);
		q_s3    <= q_s2;
	end

	// Stage 4: final mask bit
	logic v_s4;
	logic blocked_s4, oor_s4;
	logic allowed;
	logic [MW-1:0] q_x;

	always_comb begin
		q_x = MW'(q_s3);
		allowed = (same_s3 && near_s3) ||
		          (link_s3 && (q_x >= lo_s3) && (last_s3 || (q_x < hi_s3)));
	end

	always_ff @(posedge clk) begin
		blocked_s4 <= oor_s3 || !allowed;
		oor_s4     <= oor_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign done         = v_s4;
	assign blocked      = blocked_s4;
	assign out_of_range = oor_s4;

endmodule
